// ===== hdl/gradient_noise_2d_3d_defines.svh =====
// Assertion macros for the gradient noise block.
`ifndef GRADIENT_NOISE_2D_3D_DEFINES_SVH
`define GRADIENT_NOISE_2D_3D_DEFINES_SVH

// Check cons in the same cycle as ante.
`define GN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define GN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gn_pkg.sv =====
// Shared types and constants of the gradient noise block.
`default_nettype none
package gn_pkg;
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_EVAL2 = 2'd1;
  localparam logic [1:0] OP_EVAL3 = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam int COORD_W = 32;
  localparam int ENTRY_W = 8;
  localparam int NOISE_W = 19;
  localparam int IN_DATA_W = 112;
  localparam int OUT_DATA_W = 24;
  localparam int NOISE_LIMIT = 196608;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [COORD_W-1:0] z_coord;
    logic [ENTRY_W-1:0] entry_index;
    logic [ENTRY_W-1:0] entry_value;
  } item_t;
endpackage
`default_nettype wire

// ===== hdl/gn_front.sv =====
// Input side: accepts items, drops unused opcodes, queues the rest.
`default_nettype none
module gn_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // x_coord, y_coord, z_coord, entry_index, entry_value
  input  wire logic [gn_pkg::IN_DATA_W-1:0] in_tdata,
  // opcode
  input  wire logic [1:0]                   in_tuser,
  output logic                              q_valid,
  input  wire logic                         q_ready,
  output gn_pkg::item_t                     q_item
);
  import gn_pkg::*;

  item_t       slot_r [2];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  cnt_r;
  logic        push;
  logic        pop;
  item_t       in_item;

  always_comb begin
    in_item.opcode      = in_tuser;
    in_item.x_coord     = in_tdata[31:0];
    in_item.y_coord     = in_tdata[63:32];
    in_item.z_coord     = in_tdata[95:64];
    in_item.entry_index = in_tdata[103:96];
    in_item.entry_value = in_tdata[111:104];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = slot_r[rp_r];
  assign push      = in_tvalid && in_tready && (in_tuser != OP_NONE);
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wp_r] <= in_item;
        wp_r         <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/gn_back.sv =====
// Execution side: table memory, lookup sequencer, fade, gradients, interpolation.
`default_nettype none
`include "gradient_noise_2d_3d_defines.svh"
module gn_back #(
  parameter int TABLE_BITS = 8,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  output logic                            q_ready,
  input  gn_pkg::item_t                   q_item,
  output logic                            out_valid,
  input  wire logic                       out_tready,
  output logic [gn_pkg::NOISE_W-1:0]      out_noise
);
  import gn_pkg::*;

  localparam int W   = FRAC_BITS + 5;
  localparam int SW  = W + 8;
  localparam int TB  = TABLE_BITS;
  localparam int SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic signed [W-1:0] ONE_FX  = W'(64'd1 << FRAC_BITS);
  localparam logic signed [W-1:0] TEN_FX  = W'(64'd10 << FRAC_BITS);
  localparam logic signed [W-1:0] FIFT_FX = W'(64'd15 << FRAC_BITS);
  localparam logic signed [SW-1:0] LIM_P  = SW'(NOISE_LIMIT);
  localparam logic signed [SW-1:0] LIM_N  = -SW'(NOISE_LIMIT);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOK1, ST_LOOK2, ST_FADE, ST_GRAD, ST_LERPA, ST_LERPB, ST_DONE
  } phase_t;

  phase_t              phase_r;
  logic [3:0]          cnt_r;
  logic [3:0]          len_r;
  logic [2:0]          li_r;
  logic                is3d_r;
  logic [TB-1:0]       cx_r, cy_r, cz_r, a_r, b_r;
  logic [TB-1:0]       bse_r [4];
  logic [TB-1:0]       hz_r [8];
  logic signed [W-1:0] fx_r, fy_r, fz_r;
  logic signed [W-1:0] fu_r, fv_r, fw_r;
  logic signed [W-1:0] in_r, sq_r, d_r, fin_r;
  logic signed [W-1:0] q_r [8];
  logic                out_valid_r;
  logic [NOISE_W-1:0]  out_noise_r;

  logic [TB-1:0]       mem [2**TB];
  logic [TB-1:0]       rdata_r;
  logic [TB-1:0]       raddr;
  logic                mem_we;

  logic signed [W-1:0]   mul_a, mul_b, mres, ft, lt, six_t;
  logic signed [2*W-1:0] prod;
  logic signed [W-1:0]   dx, dy, dz, gu, gv, grad;
  logic [TB-1:0]         hsh;
  logic [2:0]            gi;
  logic [2:0]            lpos;
  logic signed [SW-1:0]  ext, scaled, sat;
  logic [COORD_W+TB-1:0] wx, wy, wz;

  assign q_ready   = (phase_r == ST_IDLE);
  assign mem_we    = q_valid && q_ready && (q_item.opcode == OP_LOAD);
  assign out_valid = out_valid_r;
  assign out_noise = out_noise_r;

  assign wx = {{TB{q_item.x_coord[COORD_W-1]}}, q_item.x_coord};
  assign wy = {{TB{q_item.y_coord[COORD_W-1]}}, q_item.y_coord};
  assign wz = {{TB{q_item.z_coord[COORD_W-1]}}, q_item.z_coord};

  always_comb begin
    raddr = '0;
    case (phase_r)
      ST_LOOK1: begin
        case (cnt_r)
          4'd0:    raddr = cx_r;
          4'd1:    raddr = cx_r + TB'(1);
          4'd2:    raddr = a_r;
          4'd3:    raddr = a_r + TB'(1);
          4'd4:    raddr = b_r;
          4'd5:    raddr = b_r + TB'(1);
          default: raddr = '0;
        endcase
      end
      ST_LOOK2: raddr = bse_r[cnt_r[1:0]] + cz_r + TB'(cnt_r[2]);
      default:  raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[TB'(q_item.entry_index)] <= TB'(q_item.entry_value);
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    case (cnt_r[3:2])
      2'd0:    ft = fx_r;
      2'd1:    ft = fy_r;
      default: ft = fz_r;
    endcase
    six_t = (ft <<< 2) + (ft <<< 1);
    if (is3d_r) begin
      lt = (li_r < 3'd4) ? fu_r : ((li_r < 3'd6) ? fv_r : fw_r);
    end else begin
      lt = (li_r < 3'd2) ? fu_r : fv_r;
    end
    mul_a = '0;
    mul_b = '0;
    case (phase_r)
      ST_FADE: begin
        case (cnt_r[1:0])
          2'd0: begin
            mul_a = ft;
            mul_b = six_t - FIFT_FX;
          end
          2'd1: begin
            mul_a = ft;
            mul_b = ft;
          end
          2'd2: begin
            mul_a = sq_r;
            mul_b = ft;
          end
          default: begin
            mul_a = sq_r;
            mul_b = in_r;
          end
        endcase
      end
      ST_LERPB: begin
        mul_a = lt;
        mul_b = d_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
    mres = W'(prod >>> FRAC_BITS);
  end

  always_comb begin
    gi  = cnt_r[2:0];
    hsh = is3d_r ? hz_r[gi] : bse_r[gi[1:0]];
    dx  = gi[0] ? fx_r - ONE_FX : fx_r;
    dy  = gi[1] ? fy_r - ONE_FX : fy_r;
    dz  = gi[2] ? fz_r - ONE_FX : fz_r;
    if (is3d_r) begin
      gu = (hsh[3:0] < 4'd8) ? dx : dy;
      if (hsh[3:0] < 4'd4) begin
        gv = dy;
      end else if (hsh[3:0] == 4'd12 || hsh[3:0] == 4'd14) begin
        gv = dx;
      end else begin
        gv = dz;
      end
      grad = (hsh[0] ? -gu : gu) + (hsh[1] ? -gv : gv);
    end else begin
      gu   = (hsh[2:0] < 3'd4) ? dx : dy;
      gv   = (hsh[2:0] < 3'd4) ? dy : dx;
      grad = (hsh[0] ? -gu : gu) + (hsh[1] ? -(gv <<< 1) : (gv <<< 1));
    end
    lpos   = 3'(len_r - 4'd2);
    ext    = SW'(fin_r);
    scaled = (ext >>> SHR) <<< SHL;
    if (scaled > LIM_P) begin
      sat = LIM_P;
    end else if (scaled < LIM_N) begin
      sat = LIM_N;
    end else begin
      sat = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (phase_r == ST_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (phase_r)
        ST_IDLE: begin
          if (q_valid && q_item.opcode != OP_LOAD) begin
            is3d_r  <= (q_item.opcode != OP_EVAL2);
            cx_r    <= wx[FRAC_BITS+TB-1:FRAC_BITS];
            cy_r    <= wy[FRAC_BITS+TB-1:FRAC_BITS];
            cz_r    <= wz[FRAC_BITS+TB-1:FRAC_BITS];
            fx_r    <= $signed({{(W-FRAC_BITS){1'b0}}, q_item.x_coord[FRAC_BITS-1:0]});
            fy_r    <= $signed({{(W-FRAC_BITS){1'b0}}, q_item.y_coord[FRAC_BITS-1:0]});
            fz_r    <= $signed({{(W-FRAC_BITS){1'b0}}, q_item.z_coord[FRAC_BITS-1:0]});
            cnt_r   <= '0;
            phase_r <= ST_LOOK1;
          end
        end
        ST_LOOK1: begin
          case (cnt_r)
            4'd1:    a_r <= rdata_r + cy_r;
            4'd2:    b_r <= rdata_r + cy_r;
            4'd3:    bse_r[0] <= rdata_r;
            4'd4:    bse_r[2] <= rdata_r;
            4'd5:    bse_r[1] <= rdata_r;
            4'd6:    bse_r[3] <= rdata_r;
            default: ;
          endcase
          if (cnt_r == 4'd7) begin
            cnt_r   <= '0;
            phase_r <= is3d_r ? ST_LOOK2 : ST_FADE;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_LOOK2: begin
          if (cnt_r != 4'd0) begin
            hz_r[3'(cnt_r - 4'd1)] <= rdata_r;
          end
          if (cnt_r == 4'd8) begin
            cnt_r   <= '0;
            phase_r <= ST_FADE;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_FADE: begin
          case (cnt_r[1:0])
            2'd0: in_r <= mres + TEN_FX;
            2'd1: sq_r <= mres;
            2'd2: sq_r <= mres;
            default: begin
              case (cnt_r[3:2])
                2'd0:    fu_r <= mres;
                2'd1:    fv_r <= mres;
                default: fw_r <= mres;
              endcase
            end
          endcase
          if (cnt_r == (is3d_r ? 4'd11 : 4'd7)) begin
            cnt_r   <= '0;
            phase_r <= ST_GRAD;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_GRAD: begin
          q_r[gi] <= grad;
          if (cnt_r == (is3d_r ? 4'd7 : 4'd3)) begin
            len_r   <= is3d_r ? 4'd8 : 4'd4;
            li_r    <= '0;
            cnt_r   <= '0;
            phase_r <= ST_LERPA;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_LERPA: begin
          d_r     <= q_r[1] - q_r[0];
          phase_r <= ST_LERPB;
        end
        ST_LERPB: begin
          for (int k = 0; k < 6; k++) begin
            q_r[k] <= (lpos == 3'(k)) ? q_r[0] + mres : q_r[k+2];
          end
          if (lpos == 3'd6) begin
            q_r[6] <= q_r[0] + mres;
          end
          len_r     <= len_r - 4'd1;
          li_r      <= li_r + 3'd1;
          if (len_r == 4'd2) begin
            fin_r   <= q_r[0] + mres;
            phase_r <= ST_DONE;
          end else begin
            phase_r <= ST_LERPA;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_noise_r <= NOISE_W'(sat);
            phase_r     <= ST_IDLE;
          end
        end
        default: phase_r <= ST_IDLE;
      endcase
    end
  end

  `GN_ASSERT_NEXT(a_done_out, phase_r == ST_DONE && (!out_valid_r || out_tready), out_valid_r && phase_r == ST_IDLE, "finished item not presented")
  `GN_ASSERT_NOW(a_lerp_len, phase_r == ST_LERPA || phase_r == ST_LERPB, len_r >= 4'd2, "interpolation queue underrun")
  `GN_ASSERT_NEXT(a_load_idle, phase_r == ST_IDLE && q_valid && q_item.opcode == OP_LOAD, phase_r == ST_IDLE, "load started a sequence")
endmodule
`default_nettype wire

// ===== hdl/gradient_noise_2d_3d.sv =====
// Top level of the gradient noise evaluator.
`default_nettype none
// Gradient noise evaluator, 2D and 3D. Load items (opcode 0) fill the
// permutation table; evaluate items (opcode 1 for 2D, 2 for 3D) return one
// signed Q3.16 noise value each, in order. Opcode 3 is dropped. A two-item
// queue separates input acceptance from execution. Items run one at a time,
// and an evaluation is paced by the single read port of the table memory
// (chained lookups) and the one shared multiplier used for the fade curves
// and interpolation.
// Reading a table entry that was never loaded gives an unspecified result.
module gradient_noise_2d_3d #(
  parameter int TABLE_BITS = 8,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // x_coord, y_coord, z_coord, entry_index, entry_value
  input  wire logic [gn_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  wire logic [1:0]                    in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // noise_value, zero pad
  output logic [gn_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import gn_pkg::*;

  logic               q_valid;
  logic               q_ready;
  item_t              q_item;
  logic [NOISE_W-1:0] noise;

  gn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  gn_back #(
    .TABLE_BITS (TABLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_valid  (out_tvalid),
    .out_tready (out_tready),
    .out_noise  (noise)
  );

  assign out_tdata = {{(OUT_DATA_W-NOISE_W){1'b0}}, noise};
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the gradient noise evaluator: table loads, 2D and 3D evaluations.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gn_pkg::*;

  localparam longint ONE = 64'sd65536;
  localparam int WATCH_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = OP_NONE;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  item_t pending_items[$];
  logic [NOISE_W-1:0] noise_expected[$];
  logic [7:0] perm_copy[256];
  int fail_count = 0;
  int gap_left = 0;
  int sent_count = 0;
  int noise_seen = 0;
  int hold_left = 0;
  bit long_hold_done = 0;
  int idle_cycles = 0;

  gradient_noise_2d_3d DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint fade(longint t);
    longint inner, cube;
    inner = fx_mul(t, 6 * t - 15 * ONE) + 10 * ONE;
    cube = fx_mul(fx_mul(t, t), t);
    return fx_mul(cube, inner);
  endfunction

  function automatic longint lerp(longint t, longint a, longint b);
    return a + fx_mul(t, b - a);
  endfunction

  function automatic logic [7:0] perm(int idx);
    return perm_copy[idx & 255];
  endfunction

  function automatic longint grad2(logic [7:0] hash, longint x, longint y);
    logic [2:0] h;
    longint u, v;
    h = hash[2:0];
    u = (h < 4) ? x : y;
    v = (h < 4) ? y : x;
    return (h[0] ? -u : u) + (h[1] ? -2 * v : 2 * v);
  endfunction

  function automatic longint grad3(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  task automatic predict_noise(item_t it);
    int cx, cy, cz, a, b, aa, ab, ba, bb;
    longint x, y, z, u, v, w, r;
    if (it.opcode == OP_LOAD) begin
      perm_copy[it.entry_index] = it.entry_value;
      return;
    end
    if (it.opcode == OP_NONE) return;
    cx = it.x_coord[23:16];
    cy = it.y_coord[23:16];
    cz = it.z_coord[23:16];
    x = longint'(it.x_coord[15:0]);
    y = longint'(it.y_coord[15:0]);
    z = longint'(it.z_coord[15:0]);
    u = fade(x);
    v = fade(y);
    a = perm(cx) + cy;
    b = perm(cx + 1) + cy;
    if (it.opcode == OP_EVAL2) begin
      r = lerp(v, lerp(u, grad2(perm(a), x, y), grad2(perm(b), x - ONE, y)),
                  lerp(u, grad2(perm(a + 1), x, y - ONE),
                          grad2(perm(b + 1), x - ONE, y - ONE)));
    end else begin
      w = fade(z);
      aa = perm(a) + cz;
      ab = perm(a + 1) + cz;
      ba = perm(b) + cz;
      bb = perm(b + 1) + cz;
      r = lerp(w,
            lerp(v, lerp(u, grad3(perm(aa), x, y, z), grad3(perm(ba), x - ONE, y, z)),
                    lerp(u, grad3(perm(ab), x, y - ONE, z),
                            grad3(perm(bb), x - ONE, y - ONE, z))),
            lerp(v, lerp(u, grad3(perm(aa + 1), x, y, z - ONE),
                            grad3(perm(ba + 1), x - ONE, y, z - ONE)),
                    lerp(u, grad3(perm(ab + 1), x, y - ONE, z - ONE),
                            grad3(perm(bb + 1), x - ONE, y - ONE, z - ONE))));
    end
    if (r > NOISE_LIMIT) r = NOISE_LIMIT;
    if (r < -NOISE_LIMIT) r = -NOISE_LIMIT;
    noise_expected.push_back(r[NOISE_W-1:0]);
  endtask

  function automatic int pick_gap();
    int roll;
    if ((sent_count % 300) < 80) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        it.opcode = in_tuser;
        it.x_coord = in_tdata[31:0];
        it.y_coord = in_tdata[63:32];
        it.z_coord = in_tdata[95:64];
        it.entry_index = in_tdata[103:96];
        it.entry_value = in_tdata[111:104];
        predict_noise(it);
        sent_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_tuser <= it.opcode;
          in_tdata <= {it.entry_value, it.entry_index, it.z_coord, it.y_coord, it.x_coord};
          in_tvalid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [NOISE_W-1:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        noise_seen++;
        if (noise_expected.size() == 0) begin
          $error("noise_value: unexpected item, actual %0d",
                 $signed(out_tdata[NOISE_W-1:0]));
          fail_count++;
        end else begin
          want = noise_expected.pop_front();
          if (out_tdata[NOISE_W-1:0] !== want) begin
            $error("noise_value: expected %0d actual %0d", $signed(want),
                   $signed(out_tdata[NOISE_W-1:0]));
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!long_hold_done && noise_seen >= 150) begin
        long_hold_done = 1;
        hold_left = 600;
        out_tready <= 1'b0;
      end else if ((noise_seen % 200) < 40 || $urandom_range(0, 99) < 65) begin
        out_tready <= 1'b1;
      end else begin
        hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(0, 3);
        out_tready <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (!in_tvalid && noise_expected.size() == 0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCH_LIMIT) begin
          $display("tb_top NOT OK");
          $finish;
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    int roll;
    logic [31:0] c;
    roll = $urandom_range(0, 9);
    c = $urandom;
    if (roll == 0) c[15:0] = 16'h0000;
    if (roll == 1) c[15:0] = 16'hFFFF;
    if (roll == 2) c[23:16] = 8'hFF;
    if (roll == 3) c = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
    return c;
  endfunction

  task automatic add_item(logic [1:0] op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                          logic [7:0] idx, logic [7:0] val);
    item_t it;
    it.opcode = op;
    it.x_coord = x;
    it.y_coord = y;
    it.z_coord = z;
    it.entry_index = idx;
    it.entry_value = val;
    pending_items.push_back(it);
  endtask

  initial begin
    int roll;
    for (int i = 0; i < 256; i++)
      add_item(OP_LOAD, $urandom, $urandom, $urandom, i[7:0],
               (i == 0) ? 8'd255 : (i == 255) ? 8'd0 : 8'($urandom));
    add_item(OP_EVAL2, 32'h0, 32'h0, 32'h0, 8'd0, 8'd0);
    add_item(OP_EVAL3, 32'h0, 32'h0, 32'h0, 8'd0, 8'd0);
    add_item(OP_EVAL2, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 8'd0, 8'd0);
    add_item(OP_EVAL3, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 8'd0, 8'd0);
    add_item(OP_EVAL2, 32'h80000000, 32'h80000000, 32'h80000000, 8'd0, 8'd0);
    add_item(OP_EVAL3, 32'h80000000, 32'h80000000, 32'h80000000, 8'd0, 8'd0);
    add_item(OP_EVAL3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd0, 8'd0);
    add_item(OP_EVAL3, 32'h00FF8000, 32'h00FFFFFF, 32'h00FF0001, 8'd0, 8'd0);
    add_item(OP_EVAL2, 32'h00FF8000, 32'hFF00FFFF, 32'h0, 8'd0, 8'd0);
    add_item(OP_EVAL3, 32'h00008000, 32'h00018000, 32'hFFFF8000, 8'd0, 8'd0);
    add_item(OP_NONE, 32'h12345678, 32'h0, 32'h0, 8'd7, 8'd9);
    add_item(OP_LOAD, 32'h0, 32'h0, 32'h0, 8'd255, 8'd255);
    add_item(OP_LOAD, 32'h0, 32'h0, 32'h0, 8'd0, 8'd0);
    add_item(OP_EVAL2, 32'h00FFFFFF, 32'h00FF0000, 32'h0, 8'd0, 8'd0);
    for (int i = 0; i < 980; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10)
        add_item(OP_LOAD, $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom));
      else if (roll < 15)
        add_item(OP_NONE, $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom));
      else
        add_item(roll < 55 ? OP_EVAL2 : OP_EVAL3, rand_coord(), rand_coord(), rand_coord(),
                 8'($urandom), 8'($urandom));
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0);
    @(posedge clk iff (!in_tvalid && noise_expected.size() == 0));
    repeat (200) @(posedge clk);
    if (fail_count == 0 && noise_expected.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/gn_pkg.sv
hdl/gn_front.sv
hdl/gn_back.sv
hdl/gradient_noise_2d_3d.sv
sim/tb_top.sv
